// ===== design/rvkf_pkg.sv =====
package rvkf_pkg;

  // field widths of the stream beats
  localparam int OPCODE_W  = 2;
  localparam int TIME_W    = 32;
  localparam int SLOT_W    = 4;
  localparam int KEY_W     = 8;
  localparam int DELAY_W   = 16;
  localparam int POS_W     = 4;
  localparam int NUM_CH    = 4;

  // input tdata layout, lowest bit first
  localparam int NOW_LSB     = 0;
  localparam int SLOT_LSB    = NOW_LSB + TIME_W;
  localparam int KEY_LSB     = SLOT_LSB + SLOT_W;
  localparam int DELAY_LSB   = KEY_LSB + NUM_CH * KEY_W;
  localparam int IN_USED_W   = DELAY_LSB + DELAY_W;
  localparam int IN_TDATA_W  = ((IN_USED_W + 7) / 8) * 8;

  // output tdata layout
  localparam int OUT_POS_LSB = NUM_CH * KEY_W;
  localparam int OUT_USED_W  = OUT_POS_LSB + POS_W;
  localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;

  // register port
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = PADDR_W - 2;
  localparam int COUNT_W   = 5;

  localparam logic [REG_IDX_W-1:0] REG_KEYFRAME_COUNT = '0;
  localparam logic [COUNT_W-1:0]   COUNT_RESET        = COUNT_W'(1);

  // item kinds
  localparam logic [OPCODE_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_START = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_TICK  = 2'd2;

  // microseconds to whole milliseconds
  localparam int US_PER_MS = 1000;
  localparam int MS_REM_W  = $clog2(US_PER_MS);
  localparam int TDIV_CNT_W = $clog2(TIME_W);

  typedef struct packed {
    logic mul_clr;
    logic mul_step;
    logic div_load;
    logic div_step;
  } lane_ctl_t;

endpackage

// ===== design/rvkf_div1000.sv =====
module rvkf_div1000 (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [rvkf_pkg::TIME_W-1:0] dividend,
  output logic                        done,
  output logic [rvkf_pkg::TIME_W-1:0] quotient
);

  localparam int TW = rvkf_pkg::TIME_W;
  localparam int RW = rvkf_pkg::MS_REM_W;
  localparam int CW = rvkf_pkg::TDIV_CNT_W;

  logic          run_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [TW-1:0] q_r, q_nxt;
  logic [RW-1:0] rem_r, rem_nxt;
  logic [RW:0]   trial;
  logic          ge;

  // one quotient bit a cycle, restoring against the constant
  always_comb begin
    trial   = {rem_r, q_r[TW-1]};
    ge      = trial >= (RW+1)'(rvkf_pkg::US_PER_MS);
    rem_nxt = ge ? RW'(trial - (RW+1)'(rvkf_pkg::US_PER_MS)) : trial[RW-1:0];
    q_nxt   = {q_r[TW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(TW - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
    end else if (run_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

// ===== design/rvkf_lane.sv =====
module rvkf_lane #(
  parameter int LEVEL_BITS = 8
) (
  input  logic                         clk,
  input  rvkf_pkg::lane_ctl_t          ctl,
  input  logic                         a_bit,
  input  logic                         b_bit,
  input  logic [LEVEL_BITS-1:0]        cur_lvl,
  input  logic [LEVEL_BITS-1:0]        nxt_lvl,
  input  logic [rvkf_pkg::DELAY_W-1:0] delay,
  output logic [LEVEL_BITS-1:0]        level
);

  localparam int DW = rvkf_pkg::DELAY_W;

  logic [LEVEL_BITS:0]      hi_r, hi_nxt;
  logic [DW-1:0]            lo_r, lo_nxt;
  logic [LEVEL_BITS+1:0]    psum;
  logic [LEVEL_BITS+DW:0]   prod;
  logic [DW-1:0]            rem_r, rem_nxt;
  logic [DW:0]              trial;
  logic                     ge;
  logic [LEVEL_BITS-1:0]    q_r, q_nxt;

  always_comb begin
    // shift-add, both weights serial lsb first, sum enters at the top
    psum   = (LEVEL_BITS+2)'(hi_r)
           + (a_bit ? (LEVEL_BITS+2)'(cur_lvl) : '0)
           + (b_bit ? (LEVEL_BITS+2)'(nxt_lvl) : '0);
    hi_nxt = psum[LEVEL_BITS+1:1];
    lo_nxt = {psum[0], lo_r[DW-1:1]};
    prod   = {hi_r, lo_r};
    // restoring divide, the weighted mean always fits the level width
    trial   = {rem_r, q_r[LEVEL_BITS-1]};
    ge      = trial >= {1'b0, delay};
    rem_nxt = ge ? DW'(trial - {1'b0, delay}) : trial[DW-1:0];
    q_nxt   = LEVEL_BITS'({q_r, ge});
  end

  always_ff @(posedge clk) begin
    if (ctl.mul_clr) begin
      hi_r <= '0;
      lo_r <= '0;
    end else if (ctl.mul_step) begin
      hi_r <= hi_nxt;
      lo_r <= lo_nxt;
    end
    if (ctl.div_load) begin
      rem_r <= prod[LEVEL_BITS +: DW];
      q_r   <= prod[LEVEL_BITS-1:0];
    end else if (ctl.div_step) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

  assign level = q_r;

endmodule

// ===== design/rgb_vibro_keyframe_fader.sv =====
// keyframe fader: one result beat per input beat, one item in flight at a time
// load, start, unused kind, tick with nothing to play: decoded, then the result beat registered
// tick that advances a keyframe: 32-step ms divider, compare, next keyframe read, result beat
// fading tick: ms divider, 16-step multiply and LEVEL_BITS-step divide per channel, then the
//   faded levels; next input beat taken once the result is registered
// rst_n synchronous, active low: levels, position, time stamp zero, count one, not running
module rgb_vibro_keyframe_fader #(
  parameter int MAX_KEYFRAMES = 16,
  parameter int LEVEL_BITS    = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input beats
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // now_us, slot, key_red, key_green, key_blue, key_vibration, key_delay_ms
  input  logic [rvkf_pkg::IN_TDATA_W-1:0]    in_tdata,
  // opcode
  input  logic [rvkf_pkg::OPCODE_W-1:0]      in_tuser,
  // result beats
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // red, green, blue, vibration, position
  output logic [rvkf_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // register port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [rvkf_pkg::PADDR_W-1:0]       paddr,
  input  logic [rvkf_pkg::PDATA_W-1:0]       pwdata,
  output logic [rvkf_pkg::PDATA_W-1:0]       prdata,
  output logic                               pready
);

  localparam int IDXW    = $clog2(MAX_KEYFRAMES);
  localparam int LW      = (IDXW + 1 > rvkf_pkg::COUNT_W) ? IDXW + 1 : rvkf_pkg::COUNT_W;
  localparam int DW      = rvkf_pkg::DELAY_W;
  localparam int TW      = rvkf_pkg::TIME_W;
  localparam int NCH     = rvkf_pkg::NUM_CH;
  localparam int KW      = rvkf_pkg::KEY_W;
  localparam int ENTRY_W = NCH * LEVEL_BITS + DW;
  localparam int MUL_CW  = $clog2(DW);

  typedef enum logic [3:0] {
    ST_IDLE,  // waiting for an input beat
    ST_EXEC,  // decode the item, write the table, start the ms divider
    ST_DT,    // elapsed time divided down to whole ms
    ST_CMP,   // compare with the current delay, fetch the following keyframe
    ST_NXT,   // following keyframe is out of the table
    ST_MUL,   // weights shifted through the lane multipliers
    ST_DLD,   // products into the lane dividers
    ST_DIV,   // quotient bits, msb first
    ST_LVL,   // faded levels taken
    ST_FIN    // result beat into the output register
  } state_t;

  state_t state_r;

  // item latched at the input beat
  logic [rvkf_pkg::OPCODE_W-1:0] op_r;
  logic [TW-1:0]                 now_r;
  logic [rvkf_pkg::SLOT_W-1:0]   slot_r;
  logic [ENTRY_W-1:0]            wr_entry_r;

  // playback state
  logic                          running_r;
  logic [IDXW-1:0]               frame_r;
  logic [TW-1:0]                 seg_start_r;
  logic [LEVEL_BITS-1:0]         level_r [NCH];
  logic [rvkf_pkg::COUNT_W-1:0]  count_r;

  // working registers of a tick
  logic [ENTRY_W-1:0]            rd_data_r;
  logic [LEVEL_BITS-1:0]         cur_lvl_r [NCH];
  logic [LEVEL_BITS-1:0]         nxt_lvl_r [NCH];
  logic [DW-1:0]                 cur_delay_r;
  logic [DW-1:0]                 dt_r;
  logic                          adv_r;
  logic [DW-1:0]                 a_sh_r;
  logic [DW-1:0]                 b_sh_r;
  logic [MUL_CW-1:0]             cnt_r;

  // output register
  logic                          out_tvalid_r;
  logic [rvkf_pkg::OUT_TDATA_W-1:0] out_tdata_r;

  // keyframe table
  logic [ENTRY_W-1:0]            mem [MAX_KEYFRAMES];

  logic                          in_beat;
  logic                          cfg_we;
  logic                          reg_hit;
  logic [LW-1:0]                 cnt_ext;
  logic [LW-1:0]                 cnt_eff;
  logic [LW-1:0]                 last_idx;
  logic                          at_last;
  logic                          slot_ok;
  logic                          mem_we;
  logic [IDXW-1:0]               frame_inc;
  logic [IDXW-1:0]               rd_addr;
  logic                          div_start;
  logic                          div_done;
  logic [TW-1:0]                 dt_q;
  logic [DW-1:0]                 rd_delay;
  logic                          adv;
  logic [ENTRY_W-1:0]            in_entry;
  logic [LEVEL_BITS-1:0]         lane_q [NCH];
  rvkf_pkg::lane_ctl_t           lane_ctl;
  logic [rvkf_pkg::OUT_TDATA_W-1:0] out_pack;

  assign in_beat   = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);

  // ---------------------------------------------------------------------------
  // register port, one register: keyframe count
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_hit = (paddr[rvkf_pkg::PADDR_W-1:2] == rvkf_pkg::REG_KEYFRAME_COUNT);
  assign cfg_we  = psel && penable && pwrite && pready && reg_hit;
  assign prdata  = reg_hit ? rvkf_pkg::PDATA_W'(count_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= rvkf_pkg::COUNT_RESET;
    end else if (cfg_we) begin
      count_r <= pwdata[rvkf_pkg::COUNT_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // active length: zero counts as one, anything past the table as the table
  // ---------------------------------------------------------------------------
  always_comb begin
    cnt_ext = LW'(count_r);
    if (count_r == '0) begin
      cnt_eff = LW'(1);
    end else if (cnt_ext > LW'(MAX_KEYFRAMES)) begin
      cnt_eff = LW'(MAX_KEYFRAMES);
    end else begin
      cnt_eff = cnt_ext;
    end
    last_idx  = cnt_eff - LW'(1);
    // also true when the count was lowered under a running scheme
    at_last   = LW'(frame_r) >= last_idx;
    frame_inc = frame_r + 1'b1;
    slot_ok   = LW'(slot_r) < LW'(MAX_KEYFRAMES);
  end

  // load beat packed as a table entry, levels trimmed to the level width
  always_comb begin
    in_entry = '0;
    for (int k = 0; k < NCH; k++) begin
      in_entry[k*LEVEL_BITS +: LEVEL_BITS] =
        LEVEL_BITS'(in_tdata[rvkf_pkg::KEY_LSB + k*KW +: KW]);
    end
    in_entry[NCH*LEVEL_BITS +: DW] = in_tdata[rvkf_pkg::DELAY_LSB +: DW];
  end

  // ---------------------------------------------------------------------------
  // keyframe table, one write port and one registered read port
  // the read address follows the current frame, and the one after it in the
  // compare cycle, so the registered read data is ready in the cycle after
  // ---------------------------------------------------------------------------
  assign mem_we  = (state_r == ST_EXEC) && (op_r == rvkf_pkg::OP_LOAD) && slot_ok;
  assign rd_addr = (state_r == ST_CMP) ? frame_inc : frame_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[IDXW'(slot_r)] <= wr_entry_r;
    end
    rd_data_r <= mem[rd_addr];
  end

  // ---------------------------------------------------------------------------
  // elapsed time in whole ms, serial divide of the wrapped difference
  // ---------------------------------------------------------------------------
  assign div_start = (state_r == ST_EXEC) && (op_r == rvkf_pkg::OP_TICK) &&
                     running_r && !at_last;

  rvkf_div1000 u_div1000 (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (now_r - seg_start_r),
    .done     (div_done),
    .quotient (dt_q)
  );

  // delay reached: step to the next keyframe and show its levels as they are
  assign rd_delay = rd_data_r[NCH*LEVEL_BITS +: DW];
  assign adv      = (|dt_q[TW-1:DW]) || (dt_q[DW-1:0] >= rd_delay);

  // ---------------------------------------------------------------------------
  // channel lanes: cur*(delay-dt) + next*dt, then divided by delay
  // ---------------------------------------------------------------------------
  always_comb begin
    lane_ctl.mul_clr  = (state_r == ST_NXT);
    lane_ctl.mul_step = (state_r == ST_MUL);
    lane_ctl.div_load = (state_r == ST_DLD);
    lane_ctl.div_step = (state_r == ST_DIV);
  end

  for (genvar k = 0; k < NCH; k++) begin : g_lane
    rvkf_lane #(
      .LEVEL_BITS (LEVEL_BITS)
    ) u_lane (
      .clk     (clk),
      .ctl     (lane_ctl),
      .a_bit   (a_sh_r[0]),
      .b_bit   (b_sh_r[0]),
      .cur_lvl (cur_lvl_r[k]),
      .nxt_lvl (nxt_lvl_r[k]),
      .delay   (cur_delay_r),
      .level   (lane_q[k])
    );
  end

  // result beat: four levels in their low 8 bits, position in 4 bits
  always_comb begin
    out_pack = '0;
    for (int k = 0; k < NCH; k++) begin
      out_pack[k*KW +: KW] = KW'(level_r[k]);
    end
    out_pack[rvkf_pkg::OUT_POS_LSB +: rvkf_pkg::POS_W] = rvkf_pkg::POS_W'(frame_r);
  end

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      running_r    <= 1'b0;
      frame_r      <= '0;
      seg_start_r  <= '0;
      out_tvalid_r <= 1'b0;
      cnt_r        <= '0;
      for (int k = 0; k < NCH; k++) begin
        level_r[k] <= '0;
      end
    end else begin
      // output register drains independently of the work in progress,
      // the final state refills it itself
      if (out_tvalid_r && out_tready && (state_r != ST_FIN)) begin
        out_tvalid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_beat) begin
            op_r       <= in_tuser;
            now_r      <= in_tdata[rvkf_pkg::NOW_LSB +: TW];
            slot_r     <= in_tdata[rvkf_pkg::SLOT_LSB +: rvkf_pkg::SLOT_W];
            wr_entry_r <= in_entry;
            state_r    <= ST_EXEC;
          end
        end

        ST_EXEC: begin
          case (op_r)
            rvkf_pkg::OP_START: begin
              // rewinds, restamps and runs, the levels stay as they are
              running_r   <= 1'b1;
              frame_r     <= '0;
              seg_start_r <= now_r;
              state_r     <= ST_FIN;
            end
            rvkf_pkg::OP_TICK: begin
              state_r <= div_start ? ST_DT : ST_FIN;
            end
            default: begin
              // load is written by the table port, unused kind does nothing
              state_r <= ST_FIN;
            end
          endcase
        end

        ST_DT: begin
          if (div_done) begin
            state_r <= ST_CMP;
          end
        end

        ST_CMP: begin
          for (int k = 0; k < NCH; k++) begin
            cur_lvl_r[k] <= rd_data_r[k*LEVEL_BITS +: LEVEL_BITS];
          end
          cur_delay_r <= rd_delay;
          dt_r        <= dt_q[DW-1:0];
          adv_r       <= adv;
          if (adv) begin
            frame_r     <= frame_inc;
            seg_start_r <= now_r;
          end
          state_r <= ST_NXT;
        end

        ST_NXT: begin
          if (adv_r) begin
            for (int k = 0; k < NCH; k++) begin
              level_r[k] <= rd_data_r[k*LEVEL_BITS +: LEVEL_BITS];
            end
            state_r <= ST_FIN;
          end else begin
            for (int k = 0; k < NCH; k++) begin
              nxt_lvl_r[k] <= rd_data_r[k*LEVEL_BITS +: LEVEL_BITS];
            end
            // dt below delay here, so delay is non-zero
            a_sh_r  <= cur_delay_r - dt_r;
            b_sh_r  <= dt_r;
            cnt_r   <= '0;
            state_r <= ST_MUL;
          end
        end

        ST_MUL: begin
          a_sh_r <= a_sh_r >> 1;
          b_sh_r <= b_sh_r >> 1;
          cnt_r  <= cnt_r + 1'b1;
          if (cnt_r == MUL_CW'(DW - 1)) begin
            state_r <= ST_DLD;
          end
        end

        ST_DLD: begin
          cnt_r   <= '0;
          state_r <= ST_DIV;
        end

        ST_DIV: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == MUL_CW'(LEVEL_BITS - 1)) begin
            state_r <= ST_LVL;
          end
        end

        ST_LVL: begin
          for (int k = 0; k < NCH; k++) begin
            level_r[k] <= lane_q[k];
          end
          state_r <= ST_FIN;
        end

        ST_FIN: begin
          // wait only while an earlier beat still sits unaccepted
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= out_pack;
            state_r      <= ST_IDLE;
          end
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

// ===== design/rvkf_checker.sv =====
module rvkf_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [rvkf_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // a stalled result beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // reset leaves the block empty and ready
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> in_tready && !out_tvalid)
    else $error("block not idle after reset");

  // one item in flight: no second input beat right behind the first
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while an item is in progress");

endmodule

bind rgb_vibro_keyframe_fader rvkf_checker u_rvkf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== verif/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // package names used here
  localparam int OPCODE_W    = rvkf_pkg::OPCODE_W;
  localparam int TIME_W      = rvkf_pkg::TIME_W;
  localparam int SLOT_W      = rvkf_pkg::SLOT_W;
  localparam int KEY_W       = rvkf_pkg::KEY_W;
  localparam int DELAY_W     = rvkf_pkg::DELAY_W;
  localparam int POS_W       = rvkf_pkg::POS_W;
  localparam int NUM_CH      = rvkf_pkg::NUM_CH;
  localparam int IN_TDATA_W  = rvkf_pkg::IN_TDATA_W;
  localparam int OUT_TDATA_W = rvkf_pkg::OUT_TDATA_W;
  localparam int OUT_USED_W  = rvkf_pkg::OUT_USED_W;
  localparam int PADDR_W     = rvkf_pkg::PADDR_W;
  localparam int PDATA_W     = rvkf_pkg::PDATA_W;
  localparam int COUNT_W     = rvkf_pkg::COUNT_W;
  localparam int US_PER_MS   = rvkf_pkg::US_PER_MS;

  localparam logic [OPCODE_W-1:0] OP_LOAD  = rvkf_pkg::OP_LOAD;
  localparam logic [OPCODE_W-1:0] OP_START = rvkf_pkg::OP_START;
  localparam logic [OPCODE_W-1:0] OP_TICK  = rvkf_pkg::OP_TICK;
  localparam logic [COUNT_W-1:0]  COUNT_RESET = rvkf_pkg::COUNT_RESET;

  // run length and end-of-run behaviour
  localparam int ITEM_TARGET   = 1900;
  localparam int LIMIT_CYCLES  = 1_000_000;
  localparam int SETTLE_CYCLES = 80;
  localparam int TABLE_DEPTH   = 16;

  // the one kind the block does not act on
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

  localparam logic [PADDR_W-1:0] COUNT_ADDR = {rvkf_pkg::REG_KEYFRAME_COUNT, 2'b00};

  // input beat fields, now_us in the lowest bits
  typedef struct packed {
    logic [DELAY_W-1:0] delay_ms;
    logic [KEY_W-1:0]   vib;
    logic [KEY_W-1:0]   blue;
    logic [KEY_W-1:0]   green;
    logic [KEY_W-1:0]   red;
    logic [SLOT_W-1:0]  slot;
    logic [TIME_W-1:0]  now_us;
  } key_fields_t;

  // result beat fields, red in the lowest bits
  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [KEY_W-1:0] vib;
    logic [KEY_W-1:0] blue;
    logic [KEY_W-1:0] green;
    logic [KEY_W-1:0] red;
  } drive_t;

  // one row of the directed plan: either a count write or an input beat
  typedef struct {
    bit                  is_cfg;
    logic [COUNT_W-1:0]  cfg_val;
    logic [OPCODE_W-1:0] op;
    key_fields_t         f;
    bit                  typed;
    drive_t              want;
  } plan_row_t;

  localparam drive_t ZERO_DRIVE = '0;

  logic clk = 1'b0;
  logic rst_n;

  logic                   in_tvalid;
  logic                   in_tready;
  // now_us, slot, key_red, key_green, key_blue, key_vibration, key_delay_ms
  logic [IN_TDATA_W-1:0]  in_tdata;
  // opcode
  logic [OPCODE_W-1:0]    in_tuser;
  logic                   out_tvalid;
  logic                   out_tready = 1'b1;
  // red, green, blue, vibration, position
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [PADDR_W-1:0]     paddr;
  logic [PDATA_W-1:0]     pwdata;
  logic [PDATA_W-1:0]     prdata;
  logic                   pready;

  always #5 clk = ~clk;

  rgb_vibro_keyframe_fader uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // ---------------------------------------------------------------------------
  // fader prediction: own copy of the keyframe table, playback state and count
  // ---------------------------------------------------------------------------
  logic [KEY_W-1:0]   kf_lvl [TABLE_DEPTH][NUM_CH];
  logic [DELAY_W-1:0] kf_delay [TABLE_DEPTH];
  logic [KEY_W-1:0]   lvl_now [NUM_CH];
  int                 play_pos;
  logic [TIME_W-1:0]  seg_stamp;
  bit                 playing;
  logic [COUNT_W-1:0] frame_count;

  drive_t drive_due[$];
  plan_row_t plan[$];

  int  faults     = 0;
  int  items_done = 0;
  int  burst_left = 0;
  bit  steady     = 1'b0;
  int  cycles     = 0;

  // count of 0 plays one keyframe, anything above the table depth plays all
  function automatic int active_frames();
    if (frame_count == 0) return 1;
    if (frame_count > TABLE_DEPTH) return TABLE_DEPTH;
    return int'(frame_count);
  endfunction

  function automatic drive_t step_fader(logic [OPCODE_W-1:0] op, key_fields_t f);
    int                final_pos;
    int                k;
    logic [TIME_W-1:0] elapsed;
    int unsigned       dt;
    int unsigned       d;
    longint unsigned   acc;
    bit                fading;
    drive_t            r;
    case (op)
      OP_LOAD: begin
        kf_lvl[f.slot][0] = f.red;
        kf_lvl[f.slot][1] = f.green;
        kf_lvl[f.slot][2] = f.blue;
        kf_lvl[f.slot][3] = f.vib;
        kf_delay[f.slot]  = f.delay_ms;
      end
      OP_START: begin
        // rewinds and restamps, levels stay where they are
        playing   = 1'b1;
        play_pos  = 0;
        seg_stamp = f.now_us;
      end
      OP_TICK: begin
        final_pos = active_frames() - 1;
        if (playing && play_pos < final_pos) begin
          elapsed = f.now_us - seg_stamp;
          dt      = elapsed / US_PER_MS;
          fading  = 1'b1;
          if (dt >= kf_delay[play_pos]) begin
            play_pos++;
            dt        = 0;
            lvl_now   = kf_lvl[play_pos];
            seg_stamp = f.now_us;
            if (play_pos >= final_pos) fading = 1'b0;
          end
          if (fading) begin
            d = kf_delay[play_pos];
            if (d == 0) begin
              lvl_now = kf_lvl[play_pos];
            end else begin
              for (k = 0; k < NUM_CH; k++) begin
                acc = 64'(kf_lvl[play_pos][k]) * 64'(d - dt)
                    + 64'(kf_lvl[play_pos + 1][k]) * 64'(dt);
                lvl_now[k] = KEY_W'(acc / d);
              end
            end
          end
        end
      end
      default: ;
    endcase
    r.red   = lvl_now[0];
    r.green = lvl_now[1];
    r.blue  = lvl_now[2];
    r.vib   = lvl_now[3];
    r.pos   = POS_W'(play_pos);
    return r;
  endfunction

  function automatic void note_fault(string msg);
    faults++;
    if (faults <= 10) $display("%s", msg);
  endfunction

  function automatic void check_field(string name, logic [KEY_W-1:0] exp_v,
                                      logic [KEY_W-1:0] act_v);
    if (act_v !== exp_v)
      note_fault($sformatf("%s mismatch: expected %0d, got %0d", name, exp_v, act_v));
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  // any of the four kinds, the unused one included
  function automatic logic [OPCODE_W-1:0] OP_OPCODE_ANY();
    return OPCODE_W'($urandom_range(0, 3));
  endfunction

  // mostly short fades, some zero delays, the odd very long one
  function automatic logic [DELAY_W-1:0] rand_delay();
    case ($urandom_range(0, 9))
      0:          return '0;
      1, 2, 3, 4: return DELAY_W'($urandom_range(1, 20));
      5, 6:       return DELAY_W'($urandom_range(21, 3000));
      7:          return '1;
      default:    return DELAY_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic key_fields_t noise_fields();
    key_fields_t f;
    f.now_us   = $urandom;
    f.slot     = SLOT_W'($urandom_range(0, TABLE_DEPTH - 1));
    f.red      = KEY_W'($urandom);
    f.green    = KEY_W'($urandom);
    f.blue     = KEY_W'($urandom);
    f.vib      = KEY_W'($urandom);
    f.delay_ms = rand_delay();
    return f;
  endfunction

  function automatic key_fields_t kf(logic [TIME_W-1:0] now_us, logic [SLOT_W-1:0] slot,
                                     logic [KEY_W-1:0] red, logic [KEY_W-1:0] green,
                                     logic [KEY_W-1:0] blue, logic [KEY_W-1:0] vib,
                                     logic [DELAY_W-1:0] delay_ms);
    return '{delay_ms: delay_ms, vib: vib, blue: blue, green: green, red: red,
             slot: slot, now_us: now_us};
  endfunction

  function automatic void add_beat(logic [OPCODE_W-1:0] op, key_fields_t f);
    plan.push_back('{is_cfg: 1'b0, cfg_val: '0, op: op, f: f, typed: 1'b0, want: '0});
  endfunction

  function automatic void add_known(logic [OPCODE_W-1:0] op, key_fields_t f, drive_t want);
    plan.push_back('{is_cfg: 1'b0, cfg_val: '0, op: op, f: f, typed: 1'b1, want: want});
  endfunction

  function automatic void add_count(logic [COUNT_W-1:0] val);
    plan.push_back('{is_cfg: 1'b1, cfg_val: val, op: OP_UNUSED, f: '0, typed: 1'b0,
                     want: '0});
  endfunction

  // one beat into the block; the sender idles between bursts unless steady
  task automatic send_item(input logic [OPCODE_W-1:0] op, input key_fields_t f,
                           input bit typed = 1'b0, input drive_t want = '0);
    drive_t guess;
    if (!steady && burst_left == 0) begin
      @(negedge clk) in_tvalid <= 1'b0;
      repeat ($urandom_range(0, 7)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= IN_TDATA_W'(f);
    do @(posedge clk); while (!in_tready);
    guess = step_fader(op, f);
    drive_due.push_back(typed ? want : guess);
    if (op != OP_UNUSED) items_done++;
  endtask

  // stop sending and let every outstanding result beat drain
  task automatic quiesce();
    @(negedge clk) in_tvalid <= 1'b0;
    while (drive_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // setup cycle then access cycle; pready closes the access
  task automatic reg_access(input bit wr, input logic [PDATA_W-1:0] wdata,
                            output logic [PDATA_W-1:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= COUNT_ADDR;
    pwdata  <= wdata;
    @(negedge clk) penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic write_count(input logic [COUNT_W-1:0] val);
    logic [PDATA_W-1:0] rd;
    quiesce();
    reg_access(1'b1, PDATA_W'(val), rd);
    frame_count = val;
    reg_access(1'b0, '0, rd);
    if (rd !== PDATA_W'(val))
      note_fault($sformatf("keyframe_count readback: expected %0d, got %0d", val, rd));
  endtask

  // ---------------------------------------------------------------------------
  // result side: stall pattern and checker
  // ---------------------------------------------------------------------------
  int ready_mode = 0;
  int mode_left  = 200;
  int stall_left = 0;

  // modes: always ready, coin toss per cycle, occasional long stalls
  always @(negedge clk) begin
    if (mode_left == 0) begin
      ready_mode = $urandom_range(0, 2);
      mode_left  = $urandom_range(50, 400);
    end else begin
      mode_left--;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      case (ready_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom_range(0, 1));
        default: begin
          if ($urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 8);
            out_tready <= 1'b0;
          end else begin
            out_tready <= 1'b1;
          end
        end
      endcase
    end
  end

  always @(posedge clk) begin : result_check
    drive_t got;
    drive_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = drive_t'(out_tdata[OUT_USED_W-1:0]);
      if (drive_due.size() == 0) begin
        note_fault($sformatf("result beat with nothing expected: %h", got));
      end else begin
        want = drive_due.pop_front();
        check_field("red", want.red, got.red);
        check_field("green", want.green, got.green);
        check_field("blue", want.blue, got.blue);
        check_field("vibration", want.vib, got.vib);
        check_field("position", KEY_W'(want.pos), KEY_W'(got.pos));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("rgb_vibro_keyframe_fader regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [PDATA_W-1:0] rd;
    logic [TIME_W-1:0]  clock_us;
    logic [TIME_W-1:0]  span;
    logic [COUNT_W-1:0] cnt;
    key_fields_t        f;
    int                 s;

    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = OP_LOAD;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    rst_n     = 1'b0;
    playing   = 1'b0;
    play_pos  = 0;
    seg_stamp = '0;
    frame_count = COUNT_RESET;
    foreach (lvl_now[k]) lvl_now[k] = '0;

    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // count register comes out of reset at one
    reg_access(1'b0, '0, rd);
    if (rd !== PDATA_W'(COUNT_RESET))
      note_fault($sformatf("keyframe_count after reset: expected %0d, got %0d",
                           COUNT_RESET, rd));

    // --- directed plan ---
    // tick before any start, start with a single keyframe, unused kind
    add_known(OP_TICK, kf(32'd0, 4'd0, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000), ZERO_DRIVE);
    add_known(OP_START, kf(32'd5, 4'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF), ZERO_DRIVE);
    add_known(OP_TICK, kf(32'hFFFF_FFFF, 4'hF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF),
              ZERO_DRIVE);
    add_known(OP_UNUSED, kf(32'hA5A5_5A5A, 4'h3, 8'h12, 8'h34, 8'h56, 8'h78, 16'h9ABC),
              ZERO_DRIVE);
    // fill the whole table; loads leave levels and position alone
    add_known(OP_LOAD, kf(32'd0, 4'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'd10), ZERO_DRIVE);
    add_known(OP_LOAD, kf(32'd0, 4'd1, 8'h00, 8'h00, 8'h00, 8'h00, 16'd0), ZERO_DRIVE);
    add_known(OP_LOAD, kf(32'd0, 4'd2, 8'h55, 8'hAA, 8'h0F, 8'hF0, 16'hFFFF), ZERO_DRIVE);
    add_known(OP_LOAD, kf(32'd0, 4'd3, 8'hAA, 8'h55, 8'hF0, 8'h0F, 16'd1), ZERO_DRIVE);
    for (s = 4; s < TABLE_DEPTH; s++) begin
      f = noise_fields();
      f.slot = SLOT_W'(s);
      add_known(OP_LOAD, f, ZERO_DRIVE);
    end
    // four keyframes: fade half way, advance onto a zero delay, onto the longest delay
    add_count(5'd4);
    add_known(OP_START, kf(32'd1000, 4'd0, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000),
              ZERO_DRIVE);
    add_beat(OP_TICK, kf(32'd6000, 4'd0, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000));
    add_beat(OP_TICK, kf(32'd11000, 4'd0, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000));
    add_beat(OP_TICK, kf(32'd11000, 4'd0, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000));
    add_beat(OP_TICK, kf(32'd11000 + 32'd65534999, 4'd0, 8'h00, 8'h00, 8'h00, 8'h00,
                         16'h0000));
    add_beat(OP_TICK, kf(32'd11000 + 32'd65535000, 4'd0, 8'h00, 8'h00, 8'h00, 8'h00,
                         16'h0000));
    // count of zero behaves as one: playback holds
    add_count(5'd0);
    add_beat(OP_TICK, kf(32'h8000_0000, 4'd0, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000));
    // count above the table depth, start just before the timer wraps
    add_count(5'd31);
    add_beat(OP_START, kf(32'hFFFF_FE0C, 4'd0, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000));
    add_beat(OP_TICK, kf(32'd2500, 4'd0, 8'h00, 8'h00, 8'h00, 8'h00, 16'h0000));

    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_count(plan[i].cfg_val);
      else send_item(plan[i].op, plan[i].f, plan[i].typed, plan[i].want);
    end

    // --- random phases: count change, a few loads, start, then a run of ticks ---
    clock_us = '0;
    while (items_done < ITEM_TARGET) begin
      case ($urandom_range(0, 7))
        0:       cnt = 5'd0;
        1:       cnt = 5'd1;
        2:       cnt = 5'd16;
        3:       cnt = 5'd31;
        4:       cnt = COUNT_W'($urandom_range(17, 30));
        default: cnt = COUNT_W'($urandom_range(2, 16));
      endcase
      write_count(cnt);
      steady = ($urandom_range(0, 3) == 0);

      if ($urandom_range(0, 5) == 0) begin
        // pure noise: any kind, any field
        repeat ($urandom_range(10, 40))
          send_item(OP_OPCODE_ANY(), noise_fields());
      end else begin
        repeat ($urandom_range(0, 5)) send_item(OP_LOAD, noise_fields());
        // some starts sit just below the wrap of the microsecond timer
        if ($urandom_range(0, 3) == 0) clock_us = 32'hFFFF_FFFF - $urandom_range(0, 200000);
        else clock_us = $urandom;
        f = noise_fields();
        f.now_us = clock_us;
        send_item(OP_START, f);
        repeat ($urandom_range(8, 40)) begin
          f = noise_fields();
          case ($urandom_range(0, 19))
            0: send_item(OP_UNUSED, f);
            1: send_item(OP_LOAD, f);
            2: begin
              f.now_us = clock_us;
              send_item(OP_START, f);
            end
            // time jump to anywhere
            3: send_item(OP_TICK, f);
            default: begin
              // step time relative to the delay of the keyframe now fading from
              span = TIME_W'(kf_delay[play_pos]) * US_PER_MS;
              case ($urandom_range(0, 5))
                0:       clock_us = seg_stamp + span;
                1:       clock_us = seg_stamp + span - 1;
                2:       ;
                default: clock_us = clock_us + $urandom_range(0, span / 3 + 1500);
              endcase
              f.now_us = clock_us;
              send_item(OP_TICK, f);
            end
          endcase
        end
      end
    end

    quiesce();
    if (faults == 0) begin
      $display("rgb_vibro_keyframe_fader regression: pass");
    end else begin
      $display("rgb_vibro_keyframe_fader regression: fail");
    end
    $finish;
  end

endmodule
